// ----- hdl/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// stc_pkg
// Shared widths, constants and arithmetic helpers for the transform chain
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

    localparam int CORDIC_STEPS   = 16;
    localparam int COEF_FRAC_BITS = 30;

    localparam int CORDIC_ITERS = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
    localparam int ITW          = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;

    localparam int ANG_W  = 16;
    localparam int COEF_W = 32;
    localparam int SHF_W  = 32;
    localparam int OFF_W  = 48;
    localparam int XW     = 34;
    localparam int ZW     = 36;
    localparam int ACC_W  = 66;

    localparam logic signed [COEF_W-1:0] ONE_C     = 32'sd1073741824;
    localparam logic signed [ACC_W-1:0]  ONE_A     = 66'sd1073741824;
    localparam logic signed [ZW-1:0]     PI_Z      = 36'sd3373259426;
    localparam logic signed [ZW-1:0]     HALF_PI_Z = 36'sd1686629713;
    localparam logic signed [XW-1:0]     GAIN_X    = 34'sd652032874;
    localparam logic signed [ACC_W-1:0]  HALF_LSB  = 66'sd536870912;
    localparam logic signed [ACC_W-1:0]  SAT_MAX   = 66'sd140737488355327;
    localparam logic signed [ACC_W-1:0]  SAT_MIN   = -66'sd140737488355328;

    localparam int COEF_SHIFT = 30 - COEF_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] COEF_ROUND =
        (COEF_SHIFT == 0) ? 66'sd0 : ACC_W'(66'sd1 <<< ((COEF_SHIFT == 0) ? 0 : COEF_SHIFT - 1));

    // truncated arctangent table, q.30
    function automatic logic signed [ZW-1:0] atan_q30(input logic [ITW-1:0] idx);
        logic [4:0] n;
        logic signed [ZW-1:0] r;
        n = 5'(idx);
        case (n)
            5'd0:  r = 36'sd843314856;
            5'd1:  r = 36'sd497837829;
            5'd2:  r = 36'sd263043836;
            5'd3:  r = 36'sd133525158;
            5'd4:  r = 36'sd67021686;
            5'd5:  r = 36'sd33543515;
            5'd6:  r = 36'sd16775850;
            5'd7:  r = 36'sd8388437;
            5'd8:  r = 36'sd4194282;
            5'd9:  r = 36'sd2097149;
            5'd10: r = 36'sd1048575;
            5'd11: r = 36'sd524287;
            5'd12: r = 36'sd262143;
            5'd13: r = 36'sd131071;
            5'd14: r = 36'sd65535;
            5'd15: r = 36'sd32767;
            5'd16: r = 36'sd16383;
            5'd17: r = 36'sd8191;
            5'd18: r = 36'sd4095;
            5'd19: r = 36'sd2047;
            5'd20: r = 36'sd1023;
            5'd21: r = 36'sd511;
            5'd22: r = 36'sd255;
            5'd23: r = 36'sd127;
            5'd24: r = 36'sd63;
            5'd25: r = 36'sd31;
            5'd26: r = 36'sd15;
            5'd27: r = 36'sd8;
            5'd28: r = 36'sd4;
            5'd29: r = 36'sd2;
            default: r = 36'sd0;
        endcase
        return r;
    endfunction

    // clamp to +-1.0 then round half up to the coefficient grid
    function automatic logic signed [COEF_W-1:0] quant(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = v;
        if (c > ONE_A)
        begin
            c = ONE_A;
        end
        if (c < -ONE_A)
        begin
            c = -ONE_A;
        end
        c = ((c + COEF_ROUND) >>> COEF_SHIFT) <<< COEF_SHIFT;
        return c[COEF_W-1:0];
    endfunction

    // row-major index of a 3x3 entry
    function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
        return 4'({2'b00, r} + {1'b0, r, 1'b0} + {2'b00, c});
    endfunction

endpackage

`default_nettype wire

// ----- hdl/stc_if.sv -----
// ----------------------------------------------------------------------------
// stc_pose_if / stc_row_if
// Valid/ready channels for pose items in and product rows out
// ----------------------------------------------------------------------------
`default_nettype none

interface stc_pose_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
    logic        chain_start;
    logic        chain_end;

    modport source (output valid, roll, pitch, yaw, shift_x, shift_y, shift_z,
                    chain_start, chain_end, input ready);
    modport sink   (input valid, roll, pitch, yaw, shift_x, shift_y, shift_z,
                    chain_start, chain_end, output ready);
endinterface

interface stc_row_if;
    logic        valid;
    logic        ready;
    logic [1:0]  row_index;
    logic signed [31:0] col_x;
    logic signed [31:0] col_y;
    logic signed [31:0] col_z;
    logic signed [47:0] offset;
    logic        final_row;

    modport source (output valid, row_index, col_x, col_y, col_z, offset, final_row,
                    input ready);
    modport sink   (input valid, row_index, col_x, col_y, col_z, offset, final_row,
                     output ready);
endinterface

`default_nettype wire

// ----- hdl/spatial_transform_chain_top.sv -----
// ----------------------------------------------------------------------------
// spatial_transform_chain_top
// Rigid transform chain: roll/pitch/yaw plus shift folded into a 3x4 product
// ----------------------------------------------------------------------------
// pose_in carries one transform per transfer; ready is high only while the
// block is idle. chain_start resets the running product to identity first,
// chain_end makes the block send the three rows of the product on row_out,
// row 0 to row 2, with final_row set on row 2.
// Each item runs three CORDIC passes of CORDIC_STEPS iterations on one
// add/shift unit, then 90 multiply-accumulates on a single 32x32
// multiplier (two 3x3 products to build R, the translation update, the
// product update), plus load and copy steps.
// Rows are then offered one per cycle; a stalled receiver simply holds the
// current row until it is taken, and no new pose is taken meanwhile.
// Reset clears the product to identity with zero offset and returns the
// block to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module spatial_transform_chain_top (
    input  wire logic    clk,
    input  wire logic    rst_n,
    stc_pose_if.sink     pose_in,
    stc_row_if.source    row_out
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CINIT = 4'd1;
    localparam logic [3:0] S_CRUN  = 4'd2;
    localparam logic [3:0] S_CDONE = 4'd3;
    localparam logic [3:0] S_LOAD1 = 4'd4;
    localparam logic [3:0] S_MM1   = 4'd5;
    localparam logic [3:0] S_LOAD2 = 4'd6;
    localparam logic [3:0] S_MM2   = 4'd7;
    localparam logic [3:0] S_LOAD3 = 4'd8;
    localparam logic [3:0] S_MV    = 4'd9;
    localparam logic [3:0] S_MM3   = 4'd10;
    localparam logic [3:0] S_COPY  = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic signed [15:0] ang_reg [3];
    logic signed [31:0] t_reg [3];
    logic               end_reg;

    logic signed [stc_pkg::COEF_W-1:0] rot_reg [9];
    logic signed [stc_pkg::OFF_W-1:0]  trans_reg [3];
    logic signed [stc_pkg::COEF_W-1:0] a_reg [9];
    logic signed [stc_pkg::COEF_W-1:0] b_reg [9];
    logic signed [stc_pkg::COEF_W-1:0] c_reg [9];
    logic signed [stc_pkg::OFF_W-1:0]  off_reg [3];
    logic signed [stc_pkg::COEF_W-1:0] sin_reg [3];
    logic signed [stc_pkg::COEF_W-1:0] cos_reg [3];

    logic [1:0] ang_cnt_reg;
    logic [stc_pkg::ITW-1:0] it_reg;
    logic signed [stc_pkg::XW-1:0] x_reg;
    logic signed [stc_pkg::XW-1:0] y_reg;
    logic signed [stc_pkg::ZW-1:0] z_reg;
    logic neg_reg;

    logic [1:0] i_reg;
    logic [1:0] j_reg;
    logic [1:0] k_reg;
    logic       ph_reg;
    logic signed [63:0] prod_reg;
    logic signed [stc_pkg::ACC_W-1:0] acc_reg;
    logic [1:0] row_reg;

    // cordic step
    logic signed [stc_pkg::ZW-1:0] z0;
    logic signed [stc_pkg::XW-1:0] xs;
    logic signed [stc_pkg::XW-1:0] ys;
    logic signed [stc_pkg::ZW-1:0] at;
    logic signed [stc_pkg::XW-1:0] xf;
    logic signed [stc_pkg::XW-1:0] yf;
    logic cord_last;

    assign z0 = {{3{ang_reg[ang_cnt_reg][15]}}, ang_reg[ang_cnt_reg], 17'b0};
    assign xs = x_reg >>> it_reg;
    assign ys = y_reg >>> it_reg;
    assign at = stc_pkg::atan_q30(it_reg);
    assign xf = neg_reg ? -x_reg : x_reg;
    assign yf = neg_reg ? -y_reg : y_reg;
    assign cord_last = (it_reg == stc_pkg::ITW'(stc_pkg::CORDIC_ITERS - 1));

    // mac datapath
    logic mv_mode;
    logic mm_state;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [stc_pkg::ACC_W-1:0] sum;
    logic signed [stc_pkg::ACC_W-1:0] rnd;
    logic signed [stc_pkg::ACC_W-1:0] tv;
    logic signed [stc_pkg::OFF_W-1:0] tsat;
    logic mat_last;

    assign mv_mode  = (state_reg == S_MV);
    assign mm_state = (state_reg == S_MM1) || (state_reg == S_MM2)
                   || (state_reg == S_MM3) || mv_mode;
    assign op_a = a_reg[stc_pkg::idx3(i_reg, k_reg)];
    assign op_b = mv_mode ? t_reg[k_reg] : b_reg[stc_pkg::idx3(k_reg, j_reg)];
    assign sum  = acc_reg + stc_pkg::ACC_W'(prod_reg);
    assign rnd  = (sum + stc_pkg::HALF_LSB) >>> 30;
    assign tv   = rnd + stc_pkg::ACC_W'(trans_reg[i_reg]);
    assign mat_last = ph_reg && (k_reg == 2'd2) && (i_reg == 2'd2)
                   && (mv_mode || (j_reg == 2'd2));

    always_comb
    begin
        if (tv > stc_pkg::SAT_MAX)
        begin
            tsat = stc_pkg::SAT_MAX[stc_pkg::OFF_W-1:0];
        end
        else if (tv < stc_pkg::SAT_MIN)
        begin
            tsat = stc_pkg::SAT_MIN[stc_pkg::OFF_W-1:0];
        end
        else
        begin
            tsat = tv[stc_pkg::OFF_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pose_in.valid)
                begin
                    state_next = S_CINIT;
                end
            end
            S_CINIT: state_next = S_CRUN;
            S_CRUN:
            begin
                if (cord_last)
                begin
                    state_next = S_CDONE;
                end
            end
            S_CDONE: state_next = (ang_cnt_reg == 2'd2) ? S_LOAD1 : S_CINIT;
            S_LOAD1: state_next = S_MM1;
            S_MM1:   state_next = mat_last ? S_LOAD2 : S_MM1;
            S_LOAD2: state_next = S_MM2;
            S_MM2:   state_next = mat_last ? S_LOAD3 : S_MM2;
            S_LOAD3: state_next = S_MV;
            S_MV:    state_next = mat_last ? S_MM3 : S_MV;
            S_MM3:   state_next = mat_last ? S_COPY : S_MM3;
            S_COPY:  state_next = end_reg ? S_EMIT : S_IDLE;
            S_EMIT:
            begin
                if (row_out.ready && (row_reg == 2'd2))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ang_cnt_reg <= '0;
            it_reg      <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            ph_reg      <= 1'b0;
            acc_reg     <= '0;
            row_reg     <= '0;
            end_reg     <= 1'b0;
            for (int n = 0; n < 9; n++)
            begin
                rot_reg[n] <= (n % 4 == 0) ? stc_pkg::ONE_C : '0;
            end
            for (int n = 0; n < 3; n++)
            begin
                trans_reg[n] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (pose_in.valid)
                    begin
                        ang_reg[0]  <= pose_in.roll;
                        ang_reg[1]  <= pose_in.pitch;
                        ang_reg[2]  <= pose_in.yaw;
                        t_reg[0]    <= pose_in.shift_x;
                        t_reg[1]    <= pose_in.shift_y;
                        t_reg[2]    <= pose_in.shift_z;
                        end_reg     <= pose_in.chain_end;
                        ang_cnt_reg <= '0;
                        if (pose_in.chain_start)
                        begin
                            for (int n = 0; n < 9; n++)
                            begin
                                rot_reg[n] <= (n % 4 == 0) ? stc_pkg::ONE_C : '0;
                            end
                            for (int n = 0; n < 3; n++)
                            begin
                                trans_reg[n] <= '0;
                            end
                        end
                    end
                end
                S_CINIT:
                begin
                    x_reg  <= stc_pkg::GAIN_X;
                    y_reg  <= '0;
                    it_reg <= '0;
                    if (z0 > stc_pkg::HALF_PI_Z)
                    begin
                        z_reg   <= z0 - stc_pkg::PI_Z;
                        neg_reg <= 1'b1;
                    end
                    else if (z0 < -stc_pkg::HALF_PI_Z)
                    begin
                        z_reg   <= z0 + stc_pkg::PI_Z;
                        neg_reg <= 1'b1;
                    end
                    else
                    begin
                        z_reg   <= z0;
                        neg_reg <= 1'b0;
                    end
                end
                S_CRUN:
                begin
                    if (!z_reg[stc_pkg::ZW-1])
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - at;
                    end
                    else
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + at;
                    end
                    it_reg <= it_reg + 1'b1;
                end
                S_CDONE:
                begin
                    cos_reg[ang_cnt_reg] <= stc_pkg::quant(stc_pkg::ACC_W'(xf));
                    sin_reg[ang_cnt_reg] <= stc_pkg::quant(stc_pkg::ACC_W'(yf));
                    ang_cnt_reg <= ang_cnt_reg + 2'd1;
                end
                S_LOAD1:
                begin
                    a_reg[0] <= cos_reg[2];  a_reg[1] <= -sin_reg[2]; a_reg[2] <= '0;
                    a_reg[3] <= sin_reg[2];  a_reg[4] <= cos_reg[2];  a_reg[5] <= '0;
                    a_reg[6] <= '0;          a_reg[7] <= '0;          a_reg[8] <= stc_pkg::ONE_C;
                    b_reg[0] <= cos_reg[1];  b_reg[1] <= '0;          b_reg[2] <= sin_reg[1];
                    b_reg[3] <= '0;          b_reg[4] <= stc_pkg::ONE_C; b_reg[5] <= '0;
                    b_reg[6] <= -sin_reg[1]; b_reg[7] <= '0;          b_reg[8] <= cos_reg[1];
                end
                S_LOAD2:
                begin
                    a_reg    <= c_reg;
                    b_reg[0] <= stc_pkg::ONE_C; b_reg[1] <= '0;         b_reg[2] <= '0;
                    b_reg[3] <= '0;             b_reg[4] <= cos_reg[0]; b_reg[5] <= -sin_reg[0];
                    b_reg[6] <= '0;             b_reg[7] <= sin_reg[0]; b_reg[8] <= cos_reg[0];
                end
                S_LOAD3:
                begin
                    a_reg <= rot_reg;
                    b_reg <= c_reg;
                end
                S_COPY:
                begin
                    rot_reg <= c_reg;
                    a_reg   <= c_reg;
                    off_reg <= trans_reg;
                    row_reg <= '0;
                end
                S_EMIT:
                begin
                    if (row_out.ready)
                    begin
                        row_reg <= row_reg + 2'd1;
                        for (int n = 0; n < 6; n++)
                        begin
                            a_reg[n] <= a_reg[n + 3];
                        end
                        off_reg[0] <= off_reg[1];
                        off_reg[1] <= off_reg[2];
                    end
                end
                default:
                begin
                end
            endcase

            if (mm_state)
            begin
                if (!ph_reg)
                begin
                    prod_reg <= op_a * op_b;
                    ph_reg   <= 1'b1;
                end
                else
                begin
                    ph_reg <= 1'b0;
                    if (k_reg != 2'd2)
                    begin
                        acc_reg <= sum;
                        k_reg   <= k_reg + 2'd1;
                    end
                    else
                    begin
                        acc_reg <= '0;
                        k_reg   <= '0;
                        if (mv_mode)
                        begin
                            trans_reg[i_reg] <= tsat;
                            i_reg <= (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                        end
                        else
                        begin
                            c_reg[stc_pkg::idx3(i_reg, j_reg)] <= stc_pkg::quant(rnd);
                            if (j_reg == 2'd2)
                            begin
                                j_reg <= '0;
                                i_reg <= (i_reg == 2'd2) ? 2'd0 : i_reg + 2'd1;
                            end
                            else
                            begin
                                j_reg <= j_reg + 2'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    assign pose_in.ready     = (state_reg == S_IDLE);
    assign row_out.valid     = (state_reg == S_EMIT);
    assign row_out.row_index = row_reg;
    assign row_out.col_x     = a_reg[0];
    assign row_out.col_y     = a_reg[1];
    assign row_out.col_z     = a_reg[2];
    assign row_out.offset    = off_reg[0];
    assign row_out.final_row = (row_reg == 2'd2);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (pose_in.valid && pose_in.ready) |=> !pose_in.ready)
        else $error("pose accepted while a transform is in progress");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        row_out.valid |-> !pose_in.ready)
        else $error("rows offered while accepting a pose");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (row_out.valid && row_out.ready && row_out.final_row) |=> !row_out.valid)
        else $error("row offered after the final row");

    a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(row_out.valid) |-> (row_out.row_index == 2'd0))
        else $error("row run did not start at row 0");

endmodule

`default_nettype wire
